// ===== hdl/llars_pkg.sv =====
// ----------------------------------------------------------------------------
// llars_pkg
// Shared types and constants of the row-streaming Life-like automaton unit.
// ----------------------------------------------------------------------------
package llars_pkg;

    localparam int WORD_W        = 64;
    localparam int MAX_WORDS_DEF = 64;
    localparam int MAX_ROWS_DEF  = 4096;

    localparam int RULE_W     = 9;
    localparam int WIDTH_W    = 13;
    localparam int HEIGHT_W   = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int CNT_W      = 4;

    localparam int FIFO_DEPTH = 16;

    localparam logic [RULE_W-1:0]   BIRTH_RST    = RULE_W'(8);
    localparam logic [RULE_W-1:0]   SURVIVAL_RST = RULE_W'(12);
    localparam logic [WIDTH_W-1:0]  WIDTH_RST    = WIDTH_W'(64);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST   = HEIGHT_W'(64);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BIRTH,
        REG_SURVIVAL,
        REG_WIDTH,
        REG_HEIGHT
    } t_reg_index;

    typedef struct packed {
        logic [WORD_W-1:0] next_word;
        logic              last_of_run;
        logic              end_of_frame;
    } t_result;

    typedef struct packed {
        logic [4:0] lp;
        logic [5:0] rp;
    } t_col_pad;

    typedef struct packed {
        logic              valid;
        logic              prod_a;
        logic              prod_b;
        logic              a_first;
        logic              b_first;
        logic              eof;
        logic [WORD_W-1:0] word_a;
        logic [WORD_W-1:0] word_b;
    } t_merge_req;

endpackage

// ===== hdl/llars_in_if.sv =====
// ----------------------------------------------------------------------------
// llars_in_if
// Input channel carrying one word of current-generation cells.
// ----------------------------------------------------------------------------
interface llars_in_if import llars_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] cell_word;

    modport source (output valid, output cell_word, input ready);
    modport sink (input valid, input cell_word, output ready);

endinterface

// ===== hdl/llars_out_if.sv =====
// ----------------------------------------------------------------------------
// llars_out_if
// Output channel carrying one word of next-generation cells with markers.
// ----------------------------------------------------------------------------
interface llars_out_if import llars_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] next_word;
    logic              last_of_run;
    logic              end_of_frame;

    modport source (output valid, output next_word, output last_of_run,
                    output end_of_frame, input ready);
    modport sink (input valid, input next_word, input last_of_run,
                  input end_of_frame, output ready);

endinterface

// ===== hdl/life_like_automaton_row_stream_unit.sv =====
// The first result of an accepted word is offered after the input, window,
// lane and result queue registers.
// Throughput: one input word per cycle while the 16-entry result queue has
// room; the last word of a row of more than one word yields two results.
// Reset is synchronous and active low; it restores the register defaults and
// starts a new frame. The line buffers hold no reset state.
// ----------------------------------------------------------------------------
// life_like_automaton_row_stream_unit
// One generation of a Life-like automaton over a bit-packed raster stream,
// computed by 64 parallel cell lanes for each of two result words.
// ----------------------------------------------------------------------------
module life_like_automaton_row_stream_unit import llars_pkg::*; #(
    parameter int MAX_WORDS = MAX_WORDS_DEF,
    parameter int MAX_ROWS  = MAX_ROWS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    llars_in_if.sink              i_cell,
    llars_out_if.source           o_result
);

    localparam int CW   = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int RW   = $clog2(MAX_ROWS);
    localparam int HW   = (RW > HEIGHT_W) ? RW : HEIGHT_W;
    localparam int WLIM = MAX_WORDS * WORD_W;
    localparam int LW0  = $clog2(WLIM + 1);
    localparam int LW   = (LW0 > WIDTH_W) ? LW0 : WIDTH_W;
    localparam int CRW  = $clog2(FIFO_DEPTH + 1);

    logic [RULE_W-1:0]   r_birth;
    logic [RULE_W-1:0]   r_survival;
    logic [WIDTH_W-1:0]  r_grid_width;
    logic [HEIGHT_W-1:0] r_grid_height;

    logic [LW-1:0] gw;
    logic [LW-1:0] w_eff;
    logic [LW-1:0] w_m1;
    logic [CW-1:0] words_m1;
    logic [5:0]    pad;
    t_col_pad      col_pad;
    logic [HW-1:0] gh;
    logic [HW-1:0] h_eff;
    logic [RW-1:0] row_last;

    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic          acc;
    logic [CRW-1:0] r_credit;
    logic [CRW-1:0] n_credit;
    logic          pop;

    logic              r_s1_valid;
    logic [WORD_W-1:0] r_s1_x;
    logic [CW-1:0]     r_s1_col;
    logic              r_s1_pa;
    logic              r_s1_pb;
    logic              r_s1_first;
    logic              r_s1_afirst;
    logic              r_s1_eof;

    logic              r_fwd;
    logic [WORD_W-1:0] r_fwd_up;
    logic [WORD_W-1:0] r_fwd_mid;
    logic [WORD_W-1:0] up_rd;
    logic [WORD_W-1:0] mid_rd;
    logic [WORD_W-1:0] up_eff;
    logic [WORD_W-1:0] mid_eff;

    logic [WORD_W-1:0] r_win [3][3];

    logic r_s2_valid;
    logic r_s2_pa;
    logic r_s2_pb;
    logic r_s2_afirst;
    logic r_s2_first;
    logic r_s2_eof;

    logic [WORD_W+1:0]     ext_a [3];
    logic [WORD_W+1:0]     ext_b [3];
    logic [2:0][2:0]       nbhd_a [WORD_W];
    logic [2:0][2:0]       nbhd_b [WORD_W];
    logic [WORD_W-1:0]     lane_a;
    logic [WORD_W-1:0]     lane_b;
    t_merge_req            r_s3;
    logic [1:0]            s3_push;

    // Effective geometry from the configuration registers.
    always_comb begin
        gw = LW'(r_grid_width);
        if (gw == '0) begin
            w_eff = LW'(1);
        end else if (gw > LW'(WLIM)) begin
            w_eff = LW'(WLIM);
        end else begin
            w_eff = gw;
        end
        w_m1       = w_eff - LW'(1);
        words_m1   = CW'(w_m1 >> 6);
        pad        = 6'd63 - w_m1[5:0];
        col_pad.lp = pad[5:1];
        col_pad.rp = {1'b0, pad[5:1]} + {5'd0, pad[0]};

        gh = HW'(r_grid_height);
        if (gh == '0) begin
            h_eff = HW'(1);
        end else if (gh > HW'(MAX_ROWS - 2)) begin
            h_eff = HW'(MAX_ROWS - 2);
        end else begin
            h_eff = gh;
        end
        row_last = RW'(h_eff + HW'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_birth       <= BIRTH_RST;
            r_survival    <= SURVIVAL_RST;
            r_grid_width  <= WIDTH_RST;
            r_grid_height <= HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (t_reg_index'(i_cfg_index))
                REG_BIRTH: begin
                    r_birth <= i_cfg_data[RULE_W-1:0];
                end
                REG_SURVIVAL: begin
                    r_survival <= i_cfg_data[RULE_W-1:0];
                end
                REG_WIDTH: begin
                    r_grid_width <= i_cfg_data[WIDTH_W-1:0];
                end
                REG_HEIGHT: begin
                    r_grid_height <= i_cfg_data[HEIGHT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign pop          = o_result.valid && o_result.ready;
    assign i_cell.ready = (r_credit <= CRW'(FIFO_DEPTH - 2));
    assign acc          = i_cell.valid && i_cell.ready;

    // Raster position; a configuration write restarts the frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cfg_we) begin
            r_col <= '0;
            r_row <= '0;
        end else if (acc) begin
            if (r_col == words_m1) begin
                r_col <= '0;
                r_row <= (r_row == row_last) ? '0 : r_row + RW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else begin
            r_s1_valid <= acc;
            r_fwd      <= acc && r_s1_valid && (r_col == r_s1_col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_x      <= i_cell.cell_word;
            r_s1_col    <= r_col;
            r_s1_pa     <= (r_row >= RW'(2)) && (r_col != '0);
            r_s1_pb     <= (r_row >= RW'(2)) && (r_col == words_m1);
            r_s1_first  <= (r_col == '0);
            r_s1_afirst <= (r_col == CW'(1));
            r_s1_eof    <= (r_row == row_last);
        end
        r_fwd_up  <= mid_eff;
        r_fwd_mid <= r_s1_x;
    end

    llars_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_WORDS)
    ) u_upper_line (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_col),
        .i_wdata (mid_eff),
        .i_raddr (r_col),
        .o_rdata (up_rd)
    );

    llars_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_WORDS)
    ) u_middle_line (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_col),
        .i_wdata (r_s1_x),
        .i_raddr (r_col),
        .o_rdata (mid_rd)
    );

    // A one-word row reads the entry that the previous word writes in the
    // same cycle, so that word's data is forwarded.
    assign up_eff  = r_fwd ? r_fwd_up : up_rd;
    assign mid_eff = r_fwd ? r_fwd_mid : mid_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                for (int k = 0; k < 3; k++) begin
                    r_win[r][k] <= '0;
                end
            end
        end else if (r_s1_valid) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_s1_first ? '0 : r_win[r][1];
                r_win[r][1] <= r_s1_first ? '0 : r_win[r][2];
            end
            r_win[0][2] <= up_eff;
            r_win[1][2] <= mid_eff;
            r_win[2][2] <= r_s1_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_pa     <= r_s1_pa;
        r_s2_pb     <= r_s1_pb;
        r_s2_afirst <= r_s1_afirst;
        r_s2_first  <= r_s1_first;
        r_s2_eof    <= r_s1_eof;
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            ext_a[r] = {r_win[r][2][0], r_win[r][1], r_win[r][0][WORD_W-1]};
            ext_b[r] = {1'b0, r_win[r][2], r_win[r][1][WORD_W-1]};
        end
        for (int b = 0; b < WORD_W; b++) begin
            for (int r = 0; r < 3; r++) begin
                for (int k = 0; k < 3; k++) begin
                    nbhd_a[b][r][k] = ext_a[r][b + k];
                    nbhd_b[b][r][k] = ext_b[r][b + k];
                end
            end
        end
    end

    for (genvar g = 0; g < WORD_W; g++) begin : g_lane
        llars_lane u_lane_a (
            .i_nbhd     (nbhd_a[g]),
            .i_birth    (r_birth),
            .i_survival (r_survival),
            .o_next     (lane_a[g])
        );
        llars_lane u_lane_b (
            .i_nbhd     (nbhd_b[g]),
            .i_birth    (r_birth),
            .i_survival (r_survival),
            .o_next     (lane_b[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3 <= '0;
        end else begin
            r_s3.valid   <= r_s2_valid;
            r_s3.prod_a  <= r_s2_pa;
            r_s3.prod_b  <= r_s2_pb;
            r_s3.a_first <= r_s2_afirst;
            r_s3.b_first <= r_s2_first;
            r_s3.eof     <= r_s2_eof;
            r_s3.word_a  <= lane_a;
            r_s3.word_b  <= lane_b;
        end
    end

    llars_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (r_s3),
        .i_pad    (col_pad),
        .o_result (o_result)
    );

    // Every accepted word reserves two queue slots; unused ones return at the
    // merge stage and used ones when the word leaves.
    always_comb begin
        s3_push  = 2'(r_s3.prod_a) + 2'(r_s3.prod_b);
        n_credit = r_credit + (acc ? CRW'(2) : '0)
                 - (r_s3.valid ? CRW'(2'd2 - s3_push) : '0)
                 - CRW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
        end else begin
            r_credit <= n_credit;
        end
    end

    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit <= CRW'(FIFO_DEPTH))
        else $error("result queue credit overflow");

    a_out_has_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> r_credit != '0)
        else $error("output word without a reserved slot");

    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_col == '0 && r_row == '0))
        else $error("configuration write did not restart the frame");

    a_fwd_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> words_m1 == '0)
        else $error("line buffer forwarding outside a one-word row");

endmodule

// ===== hdl/llars_ram.sv =====
// ----------------------------------------------------------------------------
// llars_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module llars_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/llars_lane.sv =====
// ----------------------------------------------------------------------------
// llars_lane
// One cell lane: counts eight neighbours and applies the birth and survival
// rule masks.
// ----------------------------------------------------------------------------
module llars_lane import llars_pkg::*; (
    input  logic [2:0][2:0]    i_nbhd,
    input  logic [RULE_W-1:0]  i_birth,
    input  logic [RULE_W-1:0]  i_survival,
    output logic               o_next
);

    logic [CNT_W-1:0] cnt;

    always_comb begin
        cnt = '0;
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                if (!(r == 1 && k == 1)) begin
                    cnt = cnt + CNT_W'(i_nbhd[r][k]);
                end
            end
        end
        o_next = i_birth[cnt] | (i_nbhd[1][1] & i_survival[cnt]);
    end

endmodule

// ===== hdl/llars_merge.sv =====
// ----------------------------------------------------------------------------
// llars_merge
// Merging stage: applies the column mask to the lane words and queues up to
// two result words per cycle for the output channel.
// ----------------------------------------------------------------------------
module llars_merge import llars_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_merge_req  i_req,
    input  t_col_pad    i_pad,
    llars_out_if.source o_result
);

    localparam int FW  = $clog2(FIFO_DEPTH);
    localparam int CRW = $clog2(FIFO_DEPTH + 1);

    t_result          r_mem [FIFO_DEPTH];
    logic [FW-1:0]    r_wp;
    logic [FW-1:0]    r_rp;
    logic [CRW-1:0]   r_count;
    logic [FW-1:0]    n_wp;
    logic [FW-1:0]    n_rp;
    logic [CRW-1:0]   n_count;
    logic             push_a;
    logic             push_b;
    logic             pop;
    logic [WORD_W-1:0] mask_left;
    logic [WORD_W-1:0] mask_right;
    t_result          res_a;
    t_result          res_b;

    assign push_a = i_req.valid && i_req.prod_a;
    assign push_b = i_req.valid && i_req.prod_b;
    assign pop    = o_result.valid && o_result.ready;

    always_comb begin
        mask_left  = {WORD_W{1'b1}} << i_pad.lp;
        mask_right = {WORD_W{1'b1}} >> i_pad.rp;
        res_a.next_word    = i_req.word_a & (i_req.a_first ? mask_left : {WORD_W{1'b1}});
        res_a.last_of_run  = !i_req.prod_b;
        res_a.end_of_frame = 1'b0;
        res_b.next_word    = i_req.word_b & mask_right
                           & (i_req.b_first ? mask_left : {WORD_W{1'b1}});
        res_b.last_of_run  = 1'b1;
        res_b.end_of_frame = i_req.eof;
    end

    always_ff @(posedge i_clk) begin
        if (push_a && push_b) begin
            r_mem[r_wp]         <= res_a;
            r_mem[r_wp + FW'(1)] <= res_b;
        end else if (push_a) begin
            r_mem[r_wp] <= res_a;
        end else if (push_b) begin
            r_mem[r_wp] <= res_b;
        end
    end

    always_comb begin
        n_wp    = r_wp + FW'(push_a) + FW'(push_b);
        n_rp    = r_rp + FW'(pop);
        n_count = r_count + CRW'(push_a) + CRW'(push_b) - CRW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    assign o_result.valid        = (r_count != '0);
    assign o_result.next_word    = r_mem[r_rp].next_word;
    assign o_result.last_of_run  = r_mem[r_rp].last_of_run;
    assign o_result.end_of_frame = r_mem[r_rp].end_of_frame;

endmodule
